FILE: design/dense_layer_bias_relu_argmax_unit_defines.svh
// Assertion macros used by the top-level RTL file of the dense layer unit.
`ifndef DENSE_LAYER_BIAS_RELU_ARGMAX_UNIT_DEFINES_SVH
`define DENSE_LAYER_BIAS_RELU_ARGMAX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DLBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DLBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DLBA_ASSERT_IMPL(label, ante, cons, msg)
`define DLBA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/dlba_pkg.sv
`default_nettype none

package dlba_pkg;

    localparam int ACC_W      = 48;
    localparam int VALUE_W    = 16;
    localparam int PROD_W     = 32;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 10;
    localparam int IN_SIZE_W  = 11;
    localparam int OUT_SIZE_W = 7;
    localparam int SIZE_CMP_W = 13;   // holds the largest input column count
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_IN_MAX  = 1024;
    localparam int DEF_OUT_MAX = 64;

    localparam logic [IN_SIZE_W-1:0]  IN_SIZE_RST  = 11'd1024;
    localparam logic [OUT_SIZE_W-1:0] OUT_SIZE_RST = 7'd64;
    localparam logic                  RELU_RST     = 1'b1;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_ELEM   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]          out_row;
        logic signed [VALUE_W-1:0] out_value;
        logic                      last;
        logic [ROW_W-1:0]          best_row;
    } result_t;

    // travels with the multiplier data
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } mul_tag_t;

endpackage

`default_nettype wire

FILE: design/dense_layer_bias_relu_argmax_unit.sv
// Weight, bias and ignored items are taken while idle, without a stall.
// Input element: the input is stalled for the whole update pass, which is set by one weight
// read per cycle feeding a single multiply-add at the entry of the rotating accumulator chain.
// Element at the last column: an unload pass follows that shifts out results, one per cycle
// while the result side does not stall.
// Reset clears control, accumulators and config (sizes max, ReLU on); stores stay unset.
`default_nettype none

`include "dense_layer_bias_relu_argmax_unit_defines.svh"

module dense_layer_bias_relu_argmax_unit import dlba_pkg::*; #(
    parameter int IN_MAX  = DEF_IN_MAX,
    parameter int OUT_MAX = DEF_OUT_MAX
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int CW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int AW = RW + CW;

    localparam logic [RW-1:0]         K_LAST    = RW'(OUT_MAX - 1);
    localparam logic [SIZE_CMP_W-1:0] IN_MAX_V  = SIZE_CMP_W'(IN_MAX);
    localparam logic [OUT_SIZE_W-1:0] OUT_MAX_V = OUT_SIZE_W'(OUT_MAX);

    // configuration
    logic [IN_SIZE_W-1:0]  in_size_reg;
    logic [OUT_SIZE_W-1:0] out_size_reg;
    logic                  relu_reg;

    // control
    state_t         state_reg, state_next;
    logic           rd_active_reg, rd_active_next;
    logic [RW-1:0]  rd_k_reg, rd_k_next;
    logic           v1_reg;
    logic [RW-1:0]  k1_reg;
    logic [RW-1:0]  em_k_reg, em_k_next;
    logic           emit_reg, emit_next;
    logic           result_valid_reg, result_valid_next;

    // payload
    logic [CW-1:0]              col_reg, col_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic                       col0_reg, col0_next;
    logic signed [VALUE_W-1:0]  best_val_reg, best_val_next;
    logic [ROW_W-1:0]           best_row_reg, best_row_next;
    result_t                    result_reg, result_next;

    logic [SIZE_CMP_W-1:0]  in_ext;
    logic [SIZE_CMP_W-1:0]  in_eff;
    logic [SIZE_CMP_W-1:0]  col_ext;
    logic [OUT_SIZE_W-1:0]  out_eff;
    logic                   row_ok;
    logic                   wcol_ok;
    logic                   col_live;
    logic                   col_is_last;

    logic                   w_we;
    logic                   b_we;
    logic [AW-1:0]          w_waddr;
    logic [AW-1:0]          w_raddr;
    logic [VALUE_W-1:0]     w_rdata;
    logic [VALUE_W-1:0]     b_rdata;

    mul_tag_t                   tag1;
    mul_tag_t                   tag2;
    logic signed [PROD_W-1:0]   product;
    logic signed [VALUE_W-1:0]  bias2;

    logic [ACC_W-1:0]  cell_acc [OUT_MAX];
    logic              cell_shift;
    logic              tail_live;
    logic              tail_add;
    logic [ACC_W-1:0]  tail_in;
    logic [ACC_W-1:0]  tail_addend;
    logic [ACC_W-1:0]  bias_wide;

    logic                      out_free;
    logic                      em_live;
    logic                      em_last;
    logic                      emit_shift;
    logic signed [VALUE_W-1:0] y;
    logic                      take;

    // floor(acc / 256), saturate to Q8.8, optional clamp at zero
    function automatic logic signed [VALUE_W-1:0] finish_value(
        input logic [ACC_W-1:0] acc,
        input logic             relu
    );
        logic [ACC_W-9:0]          q;
        logic signed [VALUE_W-1:0] s;
        q = acc[ACC_W-1:8];
        if (!q[ACC_W-9] && (|q[ACC_W-10:VALUE_W-1]))
        begin
            s = 16'sh7FFF;
        end
        else if (q[ACC_W-9] && !(&q[ACC_W-10:VALUE_W-1]))
        begin
            s = 16'sh8000;
        end
        else
        begin
            s = q[VALUE_W-1:0];
        end
        if (relu && s[VALUE_W-1])
        begin
            s = '0;
        end
        return s;
    endfunction

    // sizes out of range fall back to the nearest legal value
    assign in_ext  = SIZE_CMP_W'(in_size_reg);
    assign in_eff  = (in_size_reg == '0) ? SIZE_CMP_W'(1) :
                     ((in_ext > IN_MAX_V) ? IN_MAX_V : in_ext);
    assign out_eff = (out_size_reg == '0) ? OUT_SIZE_W'(1) :
                     ((out_size_reg > OUT_MAX_V) ? OUT_MAX_V : out_size_reg);

    assign col_ext     = SIZE_CMP_W'(item.col);
    assign row_ok      = OUT_SIZE_W'(item.row) < OUT_MAX_V;
    assign wcol_ok     = col_ext < IN_MAX_V;
    assign col_live    = col_ext < in_eff;
    assign col_is_last = col_ext == (in_eff - SIZE_CMP_W'(1));

    assign item_stall = (state_reg != ST_IDLE);

    // weight rows of one column sit next to each other
    assign w_waddr = {col_ext[CW-1:0], item.row[RW-1:0]};
    assign w_raddr = {col_reg, rd_k_reg};

    dlba_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (2 ** AW)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (item.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlba_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (OUT_MAX)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (item.row[RW-1:0]),
        .wdata (item.value),
        .raddr (rd_k_reg),
        .rdata (b_rdata)
    );

    assign tag1.valid = v1_reg;
    assign tag1.row   = ROW_W'(k1_reg);

    dlba_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (tag1),
        .weight   (w_rdata),
        .bias_in  (b_rdata),
        .value    (value_reg),
        .tag_out  (tag2),
        .product  (product),
        .bias_out (bias2)
    );

    // chain entry: bias reload on column 0, then add the product
    assign bias_wide   = {{(ACC_W - VALUE_W - 8){bias2[VALUE_W-1]}}, bias2, 8'h00};
    assign tail_live   = OUT_SIZE_W'(tag2.row) < out_eff;
    assign tail_add    = (state_reg == ST_UPDATE) && tail_live;
    assign tail_in     = (tail_add && col0_reg) ? bias_wide : cell_acc[0];
    assign tail_addend = {{(ACC_W - PROD_W){product[PROD_W-1]}}, product};

    assign out_free   = !result_valid_reg || !result_stall;
    assign em_live    = OUT_SIZE_W'(em_k_reg) < out_eff;
    assign em_last    = OUT_SIZE_W'(em_k_reg) == (out_eff - OUT_SIZE_W'(1));
    assign emit_shift = (state_reg == ST_EMIT) && (!em_live || out_free);
    assign y          = finish_value(cell_acc[0], relu_reg);
    assign take       = (em_k_reg == '0) || (y > best_val_reg);

    assign cell_shift = ((state_reg == ST_UPDATE) && tag2.valid) || emit_shift;

    for (genvar j = 0; j < OUT_MAX; j++)
    begin : g_cell
        if (j == OUT_MAX - 1)
        begin : g_tail
            dlba_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (cell_shift),
                .add_en (tail_add),
                .acc_in (tail_in),
                .addend (tail_addend),
                .acc    (cell_acc[j])
            );
        end
        else
        begin : g_body
            dlba_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (cell_shift),
                .add_en (1'b0),
                .acc_in (cell_acc[j + 1]),
                .addend ('0),
                .acc    (cell_acc[j])
            );
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        rd_active_next    = rd_active_reg;
        rd_k_next         = rd_k_reg;
        em_k_next         = em_k_reg;
        emit_next         = emit_reg;
        col_next          = col_reg;
        value_next        = value_reg;
        col0_next         = col0_reg;
        best_val_next     = best_val_reg;
        best_row_next     = best_row_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        w_we              = 1'b0;
        b_we              = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if ((item.cmd == CMD_WEIGHT) && row_ok && wcol_ok)
                    begin
                        w_we = 1'b1;
                    end
                    if ((item.cmd == CMD_BIAS) && row_ok)
                    begin
                        b_we = 1'b1;
                    end
                    if ((item.cmd == CMD_ELEM) && col_live)
                    begin
                        state_next     = ST_UPDATE;
                        rd_active_next = 1'b1;
                        rd_k_next      = '0;
                        col_next       = col_ext[CW-1:0];
                        value_next     = item.value;
                        col0_next      = (item.col == '0);
                        emit_next      = col_is_last;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (rd_active_reg)
                begin
                    if (rd_k_reg == K_LAST)
                    begin
                        rd_active_next = 1'b0;
                    end
                    else
                    begin
                        rd_k_next = rd_k_reg + RW'(1);
                    end
                end
                if (tag2.valid && (tag2.row[RW-1:0] == K_LAST))
                begin
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                    em_k_next  = '0;
                end
            end

            ST_EMIT:
            begin
                if (emit_shift)
                begin
                    if (em_live)
                    begin
                        result_valid_next     = 1'b1;
                        result_next.out_row   = ROW_W'(em_k_reg);
                        result_next.out_value = y;
                        result_next.last      = em_last;
                        result_next.best_row  = '0;
                        if (em_last)
                        begin
                            result_next.best_row = take ? ROW_W'(em_k_reg) : best_row_reg;
                        end
                        if (take)
                        begin
                            best_val_next = y;
                            best_row_next = ROW_W'(em_k_reg);
                        end
                    end
                    if (em_k_reg == K_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        em_k_next = em_k_reg + RW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_active_reg    <= 1'b0;
            rd_k_reg         <= '0;
            v1_reg           <= 1'b0;
            em_k_reg         <= '0;
            emit_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            in_size_reg      <= IN_SIZE_RST;
            out_size_reg     <= OUT_SIZE_RST;
            relu_reg         <= RELU_RST;
        end
        else
        begin
            state_reg        <= state_next;
            rd_active_reg    <= rd_active_next;
            rd_k_reg         <= rd_k_next;
            v1_reg           <= rd_active_reg;
            em_k_reg         <= em_k_next;
            emit_reg         <= emit_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IN_SIZE:  in_size_reg  <= cfg_data[IN_SIZE_W-1:0];
                    CFG_OUT_SIZE: out_size_reg <= cfg_data[OUT_SIZE_W-1:0];
                    CFG_RELU:     relu_reg     <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg       <= rd_k_reg;
        col_reg      <= col_next;
        value_reg    <= value_next;
        col0_reg     <= col0_next;
        best_val_reg <= best_val_next;
        best_row_reg <= best_row_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `DLBA_ASSERT_IMPL(a_idle_drained, state_reg == ST_IDLE, !rd_active_reg && !v1_reg && !tag2.valid, "read pipeline busy while idle")
    `DLBA_ASSERT_IMPL(a_emit_drained, state_reg == ST_EMIT, !rd_active_reg && !v1_reg && !tag2.valid, "emission overlaps the update pass")
    `DLBA_ASSERT_IMPL(a_last_row, result_valid && result.last, result.out_row == ROW_W'(out_eff - OUT_SIZE_W'(1)), "last flag on wrong row")
    `DLBA_ASSERT_IMPL(a_best_range, result_valid && result.last, result.best_row <= result.out_row, "argmax row beyond the vector")
    `DLBA_ASSERT_NEXT(a_start_pass, (state_reg == ST_IDLE) && item_valid && (item.cmd == CMD_ELEM) && col_live, rd_active_reg && (rd_k_reg == '0) && (state_reg == ST_UPDATE), "element did not start a pass")

endmodule

`default_nettype wire

FILE: design/dlba_ram.sv
`default_nettype none

module dlba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/dlba_cell.sv
`default_nettype none

module dlba_cell import dlba_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic             add_en,
    input  wire logic [ACC_W-1:0] acc_in,
    input  wire logic [ACC_W-1:0] addend,
    output logic      [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            // wraps modulo 2^48
            acc_next = add_en ? (acc_in + addend) : acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: design/dlba_mul.sv
`default_nettype none

module dlba_mul import dlba_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mul_tag_t                  tag_in,
    input  wire logic signed [VALUE_W-1:0] weight,
    input  wire logic signed [VALUE_W-1:0] bias_in,
    input  wire logic signed [VALUE_W-1:0] value,
    output mul_tag_t                       tag_out,
    output logic signed [PROD_W-1:0]       product,
    output logic signed [VALUE_W-1:0]      bias_out
);

    mul_tag_t                   tag_reg;
    logic signed [PROD_W-1:0]   product_reg;
    logic signed [PROD_W-1:0]   product_next;
    logic signed [VALUE_W-1:0]  bias_reg;

    assign product_next = weight * value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        bias_reg    <= bias_in;
    end

    assign tag_out  = tag_reg;
    assign product  = product_reg;
    assign bias_out = bias_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
    import dlba_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // worst case for an element at the last column: update pass plus unload pass
    localparam int SETTLE_CYCLES = 2 * DEF_OUT_MAX + 8;
    localparam int REPORT_MAX = 10;
    localparam int ITEM_BUDGET = 200;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    item_t item;
    logic result_valid;
    logic result_stall;
    result_t result;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dense_layer_bias_relu_argmax_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // layer state as the block should hold it
    logic signed [VALUE_W-1:0] weight_mem [DEF_OUT_MAX][DEF_IN_MAX];
    bit weight_set [DEF_OUT_MAX][DEF_IN_MAX];
    logic signed [VALUE_W-1:0] bias_mem [DEF_OUT_MAX];
    bit bias_set [DEF_OUT_MAX];
    logic [ACC_W-1:0] acc_mem [DEF_OUT_MAX];
    logic [IN_SIZE_W-1:0] in_size_q;
    logic [OUT_SIZE_W-1:0] out_size_q;
    logic relu_q;

    result_t pending_outputs [$];

    int n_items;
    int n_elems;
    int n_vectors;
    int n_results;
    int n_cfg_writes;
    int n_mismatch;
    int n_unexpected;
    bit no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("run timed out");
        $display("== FAIL ==");
        $finish;
    end

    function automatic int cols_in_use();
        if (in_size_q == 0)
            return 1;
        if (in_size_q > DEF_IN_MAX)
            return DEF_IN_MAX;
        return in_size_q;
    endfunction

    function automatic int rows_in_use();
        if (out_size_q == 0)
            return 1;
        if (out_size_q > DEF_OUT_MAX)
            return DEF_OUT_MAX;
        return out_size_q;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return 0;
        if (k < 85)
            return $urandom_range(1, 3);
        if (k < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2)
        begin
            case ($urandom_range(0, 4))
                0: return 16'sh7fff;
                1: return 16'sh8000;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end
        if (k < 6)
            return VALUE_W'(int'($urandom_range(0, 1023)) - 512);
        return VALUE_W'($urandom_range(0, 65535));
    endfunction

    function automatic item_t mk_item(logic [1:0] cmd, int row, int col,
                                      logic signed [VALUE_W-1:0] value);
        item_t it;
        it.cmd = cmd;
        it.row = ROW_W'(row);
        it.col = COL_W'(col);
        it.value = value;
        return it;
    endfunction

    // floor to Q8.8, saturate, then optional ReLU
    function automatic logic signed [VALUE_W-1:0] to_q88(logic [ACC_W-1:0] acc);
        longint v;
        v = longint'($signed(acc)) >>> 8;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        if (relu_q && v < 0)
            v = 0;
        return VALUE_W'(v);
    endfunction

    function automatic void apply_item(item_t it);
        int ni;
        int no;
        int best_r;
        logic signed [VALUE_W-1:0] outv [DEF_OUT_MAX];
        result_t res;
        ni = cols_in_use();
        no = rows_in_use();
        case (it.cmd)
            CMD_WEIGHT:
            begin
                weight_mem[it.row][it.col] = it.value;
                weight_set[it.row][it.col] = 1'b1;
            end
            CMD_BIAS:
            begin
                bias_mem[it.row] = it.value;
                bias_set[it.row] = 1'b1;
            end
            CMD_ELEM:
            begin
                if (it.col < ni)
                begin
                    n_elems++;
                    for (int r = 0; r < no; r++)
                    begin
                        if (it.col == 0)
                            acc_mem[r] = ACC_W'(longint'(bias_mem[r]) * 256);
                        acc_mem[r] = acc_mem[r] + ACC_W'(longint'(weight_mem[r][it.col])
                                                         * longint'($signed(it.value)));
                    end
                    if (it.col == ni - 1)
                    begin
                        n_vectors++;
                        best_r = 0;
                        for (int r = 0; r < no; r++)
                        begin
                            outv[r] = to_q88(acc_mem[r]);
                            if (outv[r] > outv[best_r])
                                best_r = r;
                        end
                        for (int r = 0; r < no; r++)
                        begin
                            res.out_row = ROW_W'(r);
                            res.out_value = outv[r];
                            res.last = (r == no - 1);
                            res.best_row = (r == no - 1) ? ROW_W'(best_r) : '0;
                            pending_outputs = {pending_outputs, res};
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_item(item_t it);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        n_items++;
        apply_item(it);
    endtask

    // fills in any weight or bias the element would read before it was written
    task automatic send_elem(int col, logic signed [VALUE_W-1:0] value);
        int no;
        no = rows_in_use();
        if (col < cols_in_use())
        begin
            for (int r = 0; r < no; r++)
            begin
                if (!weight_set[r][col])
                    send_item(mk_item(CMD_WEIGHT, r, col, rand_value()));
                if (col == 0 && !bias_set[r])
                    send_item(mk_item(CMD_BIAS, r, $urandom_range(0, 1023), rand_value()));
            end
        end
        send_item(mk_item(CMD_ELEM, $urandom_range(0, 63), col, value));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(int in_sz, int out_sz, bit relu);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_IN_SIZE;
        cfg_data <= CFG_DATA_W'(in_sz);
        @(posedge clk);
        in_size_q = IN_SIZE_W'(in_sz);
        cfg_index <= CFG_OUT_SIZE;
        cfg_data <= CFG_DATA_W'(out_sz);
        @(posedge clk);
        out_size_q = OUT_SIZE_W'(out_sz);
        cfg_index <= CFG_RELU;
        cfg_data <= CFG_DATA_W'(relu);
        @(posedge clk);
        relu_q = relu;
        cfg_write <= 1'b0;
        n_cfg_writes += 3;
    endtask

    task automatic test_reset_config();
        // sizes at their maximum straight out of reset
        send_elem(DEF_IN_MAX - 1, 16'sh8000);
    endtask

    task automatic test_saturation();
        set_config(1, 1, 0);
        send_item(mk_item(CMD_WEIGHT, 0, 0, 16'sh7fff));
        send_item(mk_item(CMD_BIAS, 0, 0, 16'sh7fff));
        send_elem(0, 16'sh7fff);
        send_item(mk_item(CMD_WEIGHT, 0, 0, 16'sh8000));
        send_elem(0, 16'sh8000);
        send_item(mk_item(CMD_BIAS, 0, 0, 16'sh8000));
        send_elem(0, 16'sh7fff);
        // -1/256 must floor to -1, +1/256 to 0
        send_item(mk_item(CMD_WEIGHT, 0, 0, 16'sh0001));
        send_item(mk_item(CMD_BIAS, 0, 0, 16'sh0000));
        send_elem(0, 16'shffff);
        send_elem(0, 16'sh0001);
        set_config(1, 1, 1);
        send_elem(0, 16'shffff);
        send_item(mk_item(CMD_UNUSED, 63, 1023, 16'sh7fff));
        send_elem(5, 16'sh7fff);
    endtask

    task automatic test_size_limits();
        set_config(0, 0, 0);
        send_elem(0, rand_value());
        send_elem(1, rand_value());
        set_config(2047, 127, 0);
        send_elem(DEF_IN_MAX - 1, 16'sh8000);
    endtask

    task automatic test_order_and_argmax();
        set_config(4, 4, 0);
        for (int r = 0; r < 4; r++)
        begin
            send_item(mk_item(CMD_BIAS, r, 0, 16'sh0064));
            for (int c = 0; c < 4; c++)
                send_item(mk_item(CMD_WEIGHT, r, c, 16'sh0000));
        end
        // all rows equal: argmax must pick row 0
        for (int c = 0; c < 4; c++)
            send_elem(c, rand_value());
        send_item(mk_item(CMD_BIAS, 3, 0, 16'sh00c8));
        send_item(mk_item(CMD_WEIGHT, 1, 2, 16'sh0100));
        // column 2 lands before the bias reload and is wiped by column 0
        send_elem(2, 16'sh0400);
        send_elem(0, rand_value());
        send_elem(1, rand_value());
        send_elem(1, rand_value());
        send_elem(3, rand_value());
        // no reload: accumulates on top of the previous vector
        send_elem(2, 16'sh0400);
        send_elem(3, 16'sh0000);
        set_config(4, 4, 1);
        for (int r = 0; r < 4; r++)
            send_item(mk_item(CMD_BIAS, r, 0, 16'shff00));
        for (int c = 0; c < 4; c++)
            send_elem(c, 16'sh0000);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 4))
                0: send_item(mk_item(CMD_UNUSED, $urandom_range(0, 63),
                                     $urandom_range(0, 1023), rand_value()));
                1:
                begin
                    if (cols_in_use() < DEF_IN_MAX)
                        send_item(mk_item(CMD_ELEM, $urandom_range(0, 63),
                                          $urandom_range(cols_in_use(), DEF_IN_MAX - 1),
                                          rand_value()));
                end
                2: send_item(mk_item(CMD_WEIGHT, $urandom_range(0, 63),
                                     $urandom_range(0, 1023), rand_value()));
                3: send_item(mk_item(CMD_BIAS, $urandom_range(0, 63),
                                     $urandom_range(0, 1023), rand_value()));
                default: send_elem($urandom_range(0, cols_in_use() - 1), rand_value());
            endcase
        end
    endtask

    task automatic run_vector();
        int ni;
        ni = cols_in_use();
        if (ni <= 12)
        begin
            if ($urandom_range(0, 9) == 0 && ni > 2)
                send_elem($urandom_range(1, ni - 2), rand_value());
            for (int c = 0; c < ni; c++)
                send_elem(c, rand_value());
        end
        else
        begin
            send_elem(0, rand_value());
            repeat ($urandom_range(1, 4)) send_elem($urandom_range(1, ni - 2), rand_value());
            send_elem(ni - 1, rand_value());
        end
    endtask

    // random sizes, mostly small, sent until the item budget is used up
    task automatic test_random();
        int k;
        int in_sz;
        int out_sz;
        int n_vec;
        while (n_items < ITEM_BUDGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 60)
                in_sz = $urandom_range(1, 4);
            else if (k < 75)
                in_sz = $urandom_range(5, 16);
            else if (k < 85)
                in_sz = 0;
            else if (k < 95)
                in_sz = 2047;
            else
                in_sz = DEF_IN_MAX;
            k = $urandom_range(0, 99);
            if (k < 65)
                out_sz = $urandom_range(1, 4);
            else if (k < 90)
                out_sz = $urandom_range(5, 8);
            else
                out_sz = 0;
            set_config(in_sz, out_sz, $urandom_range(0, 1));
            n_vec = $urandom_range(1, 3);
            for (int v = 0; v < n_vec && n_items < ITEM_BUDGET; v++)
            begin
                no_gaps = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 2) == 0)
                    send_noise();
                run_vector();
            end
            no_gaps = 1'b0;
            if ($urandom_range(0, 3) == 0)
                drain();
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            n_results++;
            if (pending_outputs.size() == 0)
            begin
                n_unexpected++;
                if (n_unexpected + n_mismatch <= REPORT_MAX)
                    $display("unexpected result: row %0d value %0d last %0b best %0d",
                             result.out_row, result.out_value, result.last, result.best_row);
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (result.out_row !== want.out_row || result.out_value !== want.out_value
                    || result.last !== want.last || result.best_row !== want.best_row)
                begin
                    n_mismatch++;
                    if (n_unexpected + n_mismatch <= REPORT_MAX)
                    begin
                        $display("mismatch: exp row %0d value %0d last %0b best %0d",
                                 want.out_row, want.out_value, want.last, want.best_row);
                        $display("          got row %0d value %0d last %0b best %0d",
                                 result.out_row, result.out_value, result.last,
                                 result.best_row);
                    end
                end
            end
        end
    end

    initial
    begin : drive_result_stall
        int len;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(100, 300)) @(posedge clk);
            end
            else
            begin
                len = pick_gap();
                if (len > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (len) @(posedge clk);
                end
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int guard;
        int failures;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_IN_SIZE;
        cfg_data <= '0;
        no_gaps = 1'b0;
        in_size_q = IN_SIZE_RST;
        out_size_q = OUT_SIZE_RST;
        relu_q = RELU_RST;
        foreach (acc_mem[r])
            acc_mem[r] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_saturation();
        test_size_limits();
        test_order_and_argmax();
        test_random();

        item_valid <= 1'b0;
        guard = 0;
        while (pending_outputs.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        failures = n_mismatch + n_unexpected + pending_outputs.size();
        $display("sent %0d transactions (%0d vector elements) over %0d register writes",
                 n_items, n_elems, n_cfg_writes);
        $display("checked %0d results in %0d output vectors: %0d wrong, %0d extra, %0d missing",
                 n_results, n_vectors, n_mismatch, n_unexpected, pending_outputs.size());
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/dlba_pkg.sv
design/dlba_ram.sv
design/dlba_cell.sv
design/dlba_mul.sv
design/dense_layer_bias_relu_argmax_unit.sv
tb/sv/tb.sv
